// ===== rtl/mzms_pkg.sv =====
// Shared constants and types for the mushy-zone momentum source pipeline.
package mzms_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUOT_BITS         = 31;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_INDEX_W       = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DARCY_C   = 3'd0,
        CFG_DARCY_EPS = 3'd1,
        CFG_COHERENCY = 3'd2,
        CFG_SOLIDUS   = 3'd3,
        CFG_BUOY_X    = 3'd4,
        CFG_BUOY_Y    = 3'd5,
        CFG_BUOY_Z    = 3'd6
    } cfg_index_t;

    // per-cell data carried alongside the quotient
    typedef struct packed {
        logic [31:0]        vol;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               sink;
        logic               buoy;
        logic [23:0]        dtemp;
    } cell_pay_t;

endpackage

// ===== rtl/mushy_zone_momentum_source.sv =====
// Top level: Carman-Kozeny sink and Boussinesq buoyancy, fully pipelined.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | s_valid s_ready s_alpha .. s_vel_z        | in
//  result  | m_valid m_ready m_diag_add .. m_buoy_act. | out
//  config  | cfg_we cfg_index cfg_wdata                | in
//
// One request per cycle in, one result per cycle out; the pipeline has
// four front stages, 31 restoring-divider stages (one quotient bit each),
// four multiply/accumulate stages. All stages move together on one enable,
// which is low only while a result is held at the output with m_ready low.
// Reset clears the valid bits and loads the register defaults.
module mushy_zone_momentum_source
    import mzms_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [FRACTION_BITS:0]      s_alpha,
    input  logic signed [23:0]          s_temperature,
    input  logic [31:0]                 s_volume,
    input  logic signed [31:0]          s_vel_x,
    input  logic signed [31:0]          s_vel_y,
    input  logic signed [31:0]          s_vel_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [63:0]          m_diag_add,
    output logic signed [63:0]          m_src_x,
    output logic signed [63:0]          m_src_y,
    output logic signed [63:0]          m_src_z,
    output logic                        m_sink_active,
    output logic                        m_buoyancy_active
);

    localparam int FB  = FRACTION_BITS;
    localparam int AW  = FB + 1;                       // fraction width
    localparam int NMW = 2 * FB + 1;                   // (1-a)^2 width
    localparam int CNW = 32 + NMW;                     // C*(1-a)^2 width
    localparam int PW  = CNW + 16;                     // dividend width
    localparam int DW  = ((AW > 16) ? AW : 16) + 1;    // divisor width
    localparam int QB  = QUOT_BITS;
    localparam int SW  = 82;                           // signed sum width
    localparam logic [AW-1:0] ONE_FRAC = AW'(1) << FB;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- configuration ----------------
    logic [31:0]        darcy_c_reg;
    logic [15:0]        darcy_eps_reg;
    logic [AW-1:0]      coh_reg;
    logic signed [23:0] tsol_reg;
    logic signed [31:0] buoy_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            darcy_c_reg   <= 32'd100000;
            darcy_eps_reg <= 16'd66;
            coh_reg       <= AW'(45875);
            tsol_reg      <= '0;
            buoy_reg[0]   <= '0;
            buoy_reg[1]   <= '0;
            buoy_reg[2]   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DARCY_C:   darcy_c_reg   <= cfg_wdata;
                CFG_DARCY_EPS: darcy_eps_reg <= cfg_wdata[15:0];
                CFG_COHERENCY: coh_reg       <= cfg_wdata[AW-1:0];
                CFG_SOLIDUS:   tsol_reg      <= cfg_wdata[23:0];
                CFG_BUOY_X:    buoy_reg[0]   <= cfg_wdata;
                CFG_BUOY_Y:    buoy_reg[1]   <= cfg_wdata;
                CFG_BUOY_Z:    buoy_reg[2]   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: clamp, compares ----------------
    logic              s1_val_reg;
    logic [AW-1:0]     s1_a_reg, s1_om_reg;
    cell_pay_t         s1_pay_reg;
    logic [AW-1:0]     a_clamp_next;
    logic signed [24:0] dtemp_next;
    cell_pay_t         s1_pay_next;

    always_comb begin
        a_clamp_next = (s_alpha > ONE_FRAC) ? ONE_FRAC : s_alpha;
        dtemp_next   = 25'(s_temperature) - 25'(tsol_reg);
        s1_pay_next.vol   = s_volume;
        s1_pay_next.vel_x = s_vel_x;
        s1_pay_next.vel_y = s_vel_y;
        s1_pay_next.vel_z = s_vel_z;
        s1_pay_next.sink  = a_clamp_next < coh_reg;
        s1_pay_next.buoy  = dtemp_next > 25'sd0;
        s1_pay_next.dtemp = dtemp_next[23:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_val_reg <= 1'b0;
        else if (en)  s1_val_reg <= s_valid;
        if (en) begin
            s1_a_reg   <= a_clamp_next;
            s1_om_reg  <= ONE_FRAC - a_clamp_next;
            s1_pay_reg <= s1_pay_next;
        end
    end

    // ---------------- stage 2: a^2, (1-a)^2 ----------------
    logic              s2_val_reg;
    logic [AW-1:0]     s2_a_reg, s2_a2_reg;
    logic [NMW-1:0]    s2_num_reg;
    cell_pay_t         s2_pay_reg;
    logic [2*AW-1:0]   a2_next;

    assign a2_next = (2*AW)'(s1_a_reg) * (2*AW)'(s1_a_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_val_reg <= 1'b0;
        else if (en)  s2_val_reg <= s1_val_reg;
        if (en) begin
            s2_a_reg   <= s1_a_reg;
            s2_a2_reg  <= AW'(a2_next >> FB);
            s2_num_reg <= NMW'(NMW'(s1_om_reg) * NMW'(s1_om_reg));
            s2_pay_reg <= s1_pay_reg;
        end
    end

    // ---------------- stage 3: a^3, C*(1-a)^2 ----------------
    logic              s3_val_reg;
    logic [AW-1:0]     s3_a3_reg;
    logic [CNW-1:0]    s3_cnum_reg;
    cell_pay_t         s3_pay_reg;
    logic [2*AW-1:0]   a3_next;

    assign a3_next = (2*AW)'(s2_a2_reg) * (2*AW)'(s2_a_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_val_reg <= 1'b0;
        else if (en)  s3_val_reg <= s2_val_reg;
        if (en) begin
            s3_a3_reg   <= AW'(a3_next >> FB);
            s3_cnum_reg <= CNW'(darcy_c_reg) * CNW'(s2_num_reg);
            s3_pay_reg  <= s2_pay_reg;
        end
    end

    // ---------------- stage 4 and divider ----------------
    // Quotient floor(P / D) with P = (C*(1-a)^2 << 16) >> F, D = a^3 + eps.
    // Saturation is decided up front, so the divider only produces 31 bits.
    logic [PW-1:0]     div_p_next;
    logic [DW-1:0]     div_d_next;
    logic              div_sat_next;

    always_comb begin
        div_p_next   = PW'({s3_cnum_reg, 16'b0} >> FB);
        div_d_next   = DW'(s3_a3_reg) + DW'(darcy_eps_reg);
        div_sat_next = (div_d_next == '0) ||
                       (div_p_next[PW-1:QB] >= (PW-QB)'(div_d_next));
    end

    logic              dv_val_reg [0:QB];
    logic [DW-1:0]     dv_rem_reg [0:QB];
    logic [DW-1:0]     dv_d_reg   [0:QB];
    logic [QB-1:0]     dv_low_reg [0:QB];
    logic [QB-1:0]     dv_q_reg   [0:QB];
    logic              dv_sat_reg [0:QB];
    cell_pay_t         dv_pay_reg [0:QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) dv_val_reg[0] <= 1'b0;
        else if (en)  dv_val_reg[0] <= s3_val_reg;
        if (en) begin
            dv_rem_reg[0] <= div_p_next[QB+DW-1:QB];
            dv_d_reg[0]   <= div_d_next;
            dv_low_reg[0] <= div_p_next[QB-1:0];
            dv_q_reg[0]   <= '0;
            dv_sat_reg[0] <= div_sat_next;
            dv_pay_reg[0] <= s3_pay_reg;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;

        always_comb begin
            trial    = {dv_rem_reg[k-1], dv_low_reg[k-1][QB-1]};
            ge       = trial >= {1'b0, dv_d_reg[k-1]};
            diff     = trial - {1'b0, dv_d_reg[k-1]};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_val_reg[k] <= 1'b0;
            else if (en)  dv_val_reg[k] <= dv_val_reg[k-1];
            if (en) begin
                dv_rem_reg[k] <= rem_next;
                dv_d_reg[k]   <= dv_d_reg[k-1];
                dv_low_reg[k] <= {dv_low_reg[k-1][QB-2:0], 1'b0};
                dv_q_reg[k]   <= {dv_q_reg[k-1][QB-2:0], ge};
                dv_sat_reg[k] <= dv_sat_reg[k-1];
                dv_pay_reg[k] <= dv_pay_reg[k-1];
            end
        end
    end

    logic [QB-1:0] quot;
    assign quot = dv_sat_reg[QB] ? {QB{1'b1}} : dv_q_reg[QB];

    // ---------------- stage A: first products ----------------
    logic              sa_val_reg;
    logic [63:0]       sa_diag_reg;
    logic [62:0]       sa_pv_reg [0:2];
    logic [55:0]       sa_bc_reg [0:2];
    logic [2:0]        sa_vneg_reg, sa_cneg_reg;
    cell_pay_t         sa_pay_reg;
    logic [31:0]       vel_w [0:2];
    logic [31:0]       vel_mag [0:2];
    logic [31:0]       coef_mag [0:2];
    logic [62:0]       vm_next;

    always_comb begin
        vel_w[0] = dv_pay_reg[QB].vel_x;
        vel_w[1] = dv_pay_reg[QB].vel_y;
        vel_w[2] = dv_pay_reg[QB].vel_z;
        for (int i = 0; i < 3; i++) begin
            vel_mag[i]  = vel_w[i][31] ? (32'd0 - vel_w[i]) : vel_w[i];
            coef_mag[i] = buoy_reg[i][31] ? (32'd0 - buoy_reg[i]) : buoy_reg[i];
        end
        vm_next = 63'(dv_pay_reg[QB].vol) * 63'(quot);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sa_val_reg <= 1'b0;
        else if (en)  sa_val_reg <= dv_val_reg[QB];
        if (en) begin
            sa_diag_reg <= dv_pay_reg[QB].sink ? (64'd0 - 64'(vm_next)) : 64'd0;
            for (int i = 0; i < 3; i++) begin
                sa_pv_reg[i]   <= 63'(quot) * 63'(vel_mag[i]);
                sa_bc_reg[i]   <= 56'(coef_mag[i]) * 56'(dv_pay_reg[QB].dtemp);
                sa_vneg_reg[i] <= vel_w[i][31];
                sa_cneg_reg[i] <= buoy_reg[i][31];
            end
            sa_pay_reg <= dv_pay_reg[QB];
        end
    end

    // ---------------- stage B: split products by volume ----------------
    logic              sb_val_reg;
    logic [63:0]       sb_diag_reg;
    logic [63:0]       sb_pl_reg [0:2];
    logic [62:0]       sb_ph_reg [0:2];
    logic [63:0]       sb_bl_reg [0:2];
    logic [55:0]       sb_bh_reg [0:2];
    logic [2:0]        sb_vneg_reg, sb_cneg_reg;
    logic              sb_sink_reg, sb_buoy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) sb_val_reg <= 1'b0;
        else if (en)  sb_val_reg <= sa_val_reg;
        if (en) begin
            sb_diag_reg <= sa_diag_reg;
            for (int i = 0; i < 3; i++) begin
                sb_pl_reg[i] <= 64'(sa_pv_reg[i][31:0]) * 64'(sa_pay_reg.vol);
                sb_ph_reg[i] <= 63'(sa_pv_reg[i][62:32]) * 63'(sa_pay_reg.vol);
                sb_bl_reg[i] <= 64'(sa_bc_reg[i][31:0]) * 64'(sa_pay_reg.vol);
                sb_bh_reg[i] <= 56'(sa_bc_reg[i][55:32]) * 56'(sa_pay_reg.vol);
            end
            sb_vneg_reg <= sa_vneg_reg;
            sb_cneg_reg <= sa_cneg_reg;
            sb_sink_reg <= sa_pay_reg.sink;
            sb_buoy_reg <= sa_pay_reg.buoy;
        end
    end

    // ---------------- stage C: recombine and scale ----------------
    logic              sc_val_reg;
    logic [63:0]       sc_diag_reg;
    logic [79:0]       sc_ts_reg [0:2];
    logic [79:0]       sc_tb_reg [0:2];
    logic [2:0]        sc_vneg_reg, sc_cneg_reg;
    logic              sc_sink_reg, sc_buoy_reg;
    logic [95:0]       ts_sum [0:2];
    logic [95:0]       tb_sum [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ts_sum[i] = {1'b0, sb_ph_reg[i], 32'b0} + 96'(sb_pl_reg[i]);
            tb_sum[i] = {8'b0, sb_bh_reg[i], 32'b0} + 96'(sb_bl_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sc_val_reg <= 1'b0;
        else if (en)  sc_val_reg <= sb_val_reg;
        if (en) begin
            sc_diag_reg <= sb_diag_reg;
            for (int i = 0; i < 3; i++) begin
                sc_ts_reg[i] <= ts_sum[i][95:16];
                sc_tb_reg[i] <= tb_sum[i][87:8];
            end
            sc_vneg_reg <= sb_vneg_reg;
            sc_cneg_reg <= sb_cneg_reg;
            sc_sink_reg <= sb_sink_reg;
            sc_buoy_reg <= sb_buoy_reg;
        end
    end

    // ---------------- stage D: signed sum, saturate, output ----------------
    logic              out_val_reg;
    logic [63:0]       out_diag_reg;
    logic [63:0]       out_src_reg [0:2];
    logic              out_sink_reg, out_buoy_reg;
    logic signed [SW-1:0] sterm [0:2];
    logic signed [SW-1:0] bterm [0:2];
    logic signed [SW-1:0] acc   [0:2];
    logic [63:0]       src_next [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!sc_sink_reg)        sterm[i] = '0;
            else if (sc_vneg_reg[i]) sterm[i] = SW'(sc_ts_reg[i]);
            else                     sterm[i] = -SW'(sc_ts_reg[i]);
            if (!sc_buoy_reg)        bterm[i] = '0;
            else if (sc_cneg_reg[i]) bterm[i] = -SW'(sc_tb_reg[i]);
            else                     bterm[i] = SW'(sc_tb_reg[i]);
            acc[i] = sterm[i] + bterm[i];
            if (acc[i][SW-1:63] == '0 || acc[i][SW-1:63] == '1)
                src_next[i] = acc[i][63:0];
            else if (acc[i][SW-1])
                src_next[i] = {1'b1, 63'b0};
            else
                src_next[i] = {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_val_reg <= 1'b0;
        else if (en)  out_val_reg <= sc_val_reg;
        if (en) begin
            out_diag_reg <= sc_diag_reg;
            for (int i = 0; i < 3; i++) out_src_reg[i] <= src_next[i];
            out_sink_reg <= sc_sink_reg;
            out_buoy_reg <= sc_buoy_reg;
        end
    end

    assign m_valid           = out_val_reg;
    assign m_diag_add        = out_diag_reg;
    assign m_src_x           = out_src_reg[0];
    assign m_src_y           = out_src_reg[1];
    assign m_src_z           = out_src_reg[2];
    assign m_sink_active     = out_sink_reg;
    assign m_buoyancy_active = out_buoy_reg;

    // ---------------- checks ----------------
    a_no_sink_no_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sink_active |-> m_diag_add == 64'sd0)
        else $error("diagonal set without sink");

    a_sink_diag_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sink_active |-> !(m_diag_add > 64'sd0))
        else $error("sink diagonal positive");

    a_idle_src_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sink_active && !m_buoyancy_active |->
            m_src_x == 64'sd0 && m_src_y == 64'sd0 && m_src_z == 64'sd0)
        else $error("source without active term");

    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(dv_q_reg[QB]) && $stable(dv_val_reg[QB]))
        else $error("divider moved during stall");

endmodule

// ===== test/testbench.sv =====
// Testbench for mushy_zone_momentum_source: streams cells and checks each result against a predictor.
`timescale 1ns / 1ps

module testbench;
    import mzms_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [16:0] FRAC_ONE = 17'd65536;
    localparam logic [63:0] QUOT_CAP = 64'h7FFF_FFFF;
    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        logic [16:0]        alpha;
        logic signed [23:0] temperature;
        logic [31:0]        volume;
        logic signed [31:0] vel [3];
    } cell_t;

    typedef struct {
        logic signed [63:0] diag_add;
        logic signed [63:0] src [3];
        logic               sink;
        logic               buoy;
    } momentum_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [16:0] s_alpha = '0;
    logic signed [23:0] s_temperature = '0;
    logic [31:0] s_volume = '0;
    logic signed [31:0] s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [63:0] m_diag_add, m_src_x, m_src_y, m_src_z;
    logic m_sink_active, m_buoyancy_active;

    // shadow copy of the register file
    logic [31:0] darcy_c = 32'd100000;
    logic [15:0] darcy_eps = 16'd66;
    logic [16:0] coherency = 17'd45875;
    logic signed [23:0] solidus = '0;
    logic signed [31:0] buoy_coef [3] = '{0, 0, 0};

    cell_t pending_cells [$];
    momentum_t expected_momentum [$];
    int cycle_count = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int sink_seen = 0;
    int buoy_seen = 0;
    int stall_left = 0;
    bit stall_done = 0;

    always #4 aclk = ~aclk;

    mushy_zone_momentum_source DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_alpha(s_alpha),
        .s_temperature(s_temperature), .s_volume(s_volume),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y), .s_vel_z(s_vel_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_diag_add(m_diag_add),
        .m_src_x(m_src_x), .m_src_y(m_src_y), .m_src_z(m_src_z),
        .m_sink_active(m_sink_active), .m_buoyancy_active(m_buoyancy_active)
    );

    function automatic momentum_t darcy_buoyancy(cell_t c);
        logic [16:0] a;
        logic [63:0] om, a3, den, quot;
        logic [127:0] num, q, w_quot, w_mag, w_vol, w_dt, t;
        logic signed [127:0] acc [3];
        logic signed [24:0] dtemp;
        logic [31:0] mag;
        momentum_t r;
        a = (c.alpha > FRAC_ONE) ? FRAC_ONE : c.alpha;
        r.sink = a < coherency;
        r.diag_add = '0;
        for (int i = 0; i < 3; i++) acc[i] = '0;
        w_vol = {96'b0, c.volume};
        if (r.sink) begin
            om = 64'(FRAC_ONE) - 64'(a);
            a3 = (((64'(a) * 64'(a)) >> 16) * 64'(a)) >> 16;
            den = (a3 + 64'(darcy_eps)) << 16;
            num = ({96'b0, darcy_c} << 16) * {64'b0, om * om};
            if (den == 0) begin
                quot = QUOT_CAP;
            end else begin
                q = num / {64'b0, den};
                quot = (q > {64'b0, QUOT_CAP}) ? QUOT_CAP : q[63:0];
            end
            r.diag_add = 64'd0 - 64'(c.volume) * quot;
            w_quot = {64'b0, quot};
            for (int i = 0; i < 3; i++) begin
                mag = c.vel[i][31] ? (~c.vel[i] + 32'd1) : c.vel[i];
                w_mag = {96'b0, mag};
                t = (w_quot * w_mag * w_vol) >> 16;
                acc[i] = c.vel[i][31] ? $signed(t) : -$signed(t);
            end
        end
        dtemp = $signed({c.temperature[23], c.temperature}) - $signed({solidus[23], solidus});
        r.buoy = dtemp > 0;
        if (r.buoy) begin
            w_dt = {103'b0, dtemp[24:0]};
            for (int i = 0; i < 3; i++) begin
                mag = buoy_coef[i][31] ? (~buoy_coef[i] + 32'd1) : buoy_coef[i];
                w_mag = {96'b0, mag};
                t = (w_mag * w_dt * w_vol) >> 8;
                acc[i] = acc[i] + (buoy_coef[i][31] ? -$signed(t) : $signed(t));
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (acc[i] > SAT_HI) r.src[i] = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (acc[i] < SAT_LO) r.src[i] = 64'h8000_0000_0000_0000;
            else r.src[i] = acc[i][63:0];
        end
        return r;
    endfunction

    function automatic bit idle_roll();
        // quiet stretch: no idling on either side
        if (cycle_count > 1500 && cycle_count < 3000) return 0;
        return $urandom_range(99) < 26;
    endfunction

    // sender
    always @(posedge aclk) begin
        cell_t c;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                c.alpha = s_alpha;
                c.temperature = s_temperature;
                c.volume = s_volume;
                c.vel[0] = s_vel_x;
                c.vel[1] = s_vel_y;
                c.vel[2] = s_vel_z;
                expected_momentum.push_back(darcy_buoyancy(c));
            end
            if (!s_valid || s_ready) begin
                if (pending_cells.size() != 0 && !idle_roll()) begin
                    c = pending_cells.pop_front();
                    s_valid <= 1'b1;
                    s_alpha <= c.alpha;
                    s_temperature <= c.temperature;
                    s_volume <= c.volume;
                    s_vel_x <= c.vel[0];
                    s_vel_y <= c.vel[1];
                    s_vel_z <= c.vel[2];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        momentum_t e;
        bit bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_momentum.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
                end else begin
                    e = expected_momentum.pop_front();
                    sink_seen += e.sink;
                    buoy_seen += e.buoy;
                    bad = (m_diag_add !== e.diag_add) || (m_src_x !== e.src[0]) ||
                          (m_src_y !== e.src[1]) || (m_src_z !== e.src[2]) ||
                          (m_sink_active !== e.sink) || (m_buoyancy_active !== e.buoy);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch #%0d: diag exp %0d got %0d", results_seen,
                                     e.diag_add, m_diag_add);
                            $display("  src exp %0d %0d %0d got %0d %0d %0d",
                                     e.src[0], e.src[1], e.src[2], m_src_x, m_src_y, m_src_z);
                            $display("  sink/buoy exp %b%b got %b%b", e.sink, e.buoy,
                                     m_sink_active, m_buoyancy_active);
                        end
                    end
                end
            end
            // one long hold-off so the pipeline fills and backs up the input
            if (!stall_done && results_seen == 150) begin
                stall_done <= 1;
                stall_left <= 250;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= (stall_left == 1);
            end else begin
                m_ready <= !idle_roll();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL mushy_zone_momentum_source");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_DARCY_C:   darcy_c = data;
            CFG_DARCY_EPS: darcy_eps = data[15:0];
            CFG_COHERENCY: coherency = data[16:0];
            CFG_SOLIDUS:   solidus = data[23:0];
            CFG_BUOY_X:    buoy_coef[0] = data;
            CFG_BUOY_Y:    buoy_coef[1] = data;
            CFG_BUOY_Z:    buoy_coef[2] = data;
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [31:0] c, logic [15:0] eps, logic [16:0] coh,
                           logic [23:0] sol, logic [31:0] bx, logic [31:0] by,
                           logic [31:0] bz);
        cfg_write(CFG_DARCY_C, c);
        cfg_write(CFG_DARCY_EPS, {16'b0, eps});
        cfg_write(CFG_COHERENCY, {15'b0, coh});
        cfg_write(CFG_SOLIDUS, {8'b0, sol});
        cfg_write(CFG_BUOY_X, bx);
        cfg_write(CFG_BUOY_Y, by);
        cfg_write(CFG_BUOY_Z, bz);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_cell(logic [16:0] a, logic [23:0] t, logic [31:0] v,
                            logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
        cell_t c;
        c.alpha = a;
        c.temperature = t;
        c.volume = v;
        c.vel[0] = ux;
        c.vel[1] = uy;
        c.vel[2] = uz;
        pending_cells.push_back(c);
    endtask

    task automatic add_random_cells(int n);
        logic [16:0] a;
        logic [23:0] t;
        logic [31:0] v;
        int d;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                6: a = (coherency > 2) ? 17'(coherency - 17'($urandom_range(2)))
                                       : 17'($urandom_range(3));
                7: a = 17'($urandom_range(131071, 65537));
                8: a = $urandom_range(1) ? FRAC_ONE : 17'd0;
                9: a = 17'($urandom_range(2000));
                default: a = 17'($urandom_range(65536));
            endcase
            if ($urandom_range(1)) begin
                t = 24'($urandom);
            end else begin
                d = int'(solidus) + int'($urandom_range(4000)) - 2000;
                if (d > 8388607) d = 8388607;
                if (d < -8388608) d = -8388608;
                t = d[23:0];
            end
            case ($urandom_range(3))
                0: v = $urandom_range(1000);
                1: v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                default: v = $urandom;
            endcase
            add_cell(a, t, v, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic drain();
        while (pending_cells.size() != 0 || s_valid || expected_momentum.size() != 0)
            @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: fraction edges, temperature edges, volume and velocity extremes
        add_cell(17'd0, 24'h7FFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        add_cell(17'd65536, 24'h800000, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_cell(17'h1FFFF, 24'd1, 32'd1, 32'd65536, 32'd1, 32'h8000_0000);
        add_cell(17'd45874, 24'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_cell(17'd45875, 24'd1, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
        add_cell(17'd1, 24'hFFFFFF, 32'd12345, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_random_cells(300);
        drain();

        // strong sink, zero epsilon (zero denominator), full coherency, extreme buoyancy
        cfg_all(32'hFFFF_FFFF, 16'd0, 17'd65536, 24'h800000,
                32'h7FFF_FFFF, 32'h8000_0000, $urandom);
        cfg_write(CFG_UNUSED, $urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
        add_cell(17'd0, 24'h7FFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5);
        add_cell(17'd40, 24'h7FFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        add_cell(17'd65535, 24'h800001, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'hFFFF_FFF0);
        add_cell(17'd65536, 24'h7FFFFF, 32'd1, 32'd0, 32'd0, 32'd0);
        add_random_cells(300);
        drain();

        // sink off, buoyancy never
        cfg_all(32'd0, 16'hFFFF, 17'd0, 24'h7FFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        add_cell(17'd0, 24'h7FFFFF, 32'hFFFF_FFFF, 32'd3, 32'd3, 32'd3);
        add_random_cells(150);
        drain();

        for (int p = 0; p < 4; p++) begin
            cfg_all($urandom, 16'($urandom), 17'($urandom_range(65536)), 24'($urandom),
                    $urandom, $urandom, $urandom);
            add_random_cells(280);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("checked %0d cells: %0d with the Darcy sink, %0d with buoyancy",
                 results_seen, sink_seen, buoy_seen);
        $display("covered 7 register settings incl. extremes, one long output stall");
        if (mismatches == 0 && expected_momentum.size() == 0) begin
            $display("PASS mushy_zone_momentum_source");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_momentum.size());
            $display("FAIL mushy_zone_momentum_source");
        end
        $finish;
    end

endmodule
